// File: sv/hsvcrm_pkg.sv
// hsvcrm_pkg: shared types, color mode codes, band limits and reciprocal tables
// for the hsv color range mask; no dependencies
`timescale 1ns / 1ps

package hsvcrm_pkg;

   // color mode codes held in the csr register
   typedef enum logic [3:0] {
      MODE_FULL       = 4'd0,
      MODE_BROWN      = 4'd1,
      MODE_RED        = 4'd2,
      MODE_WHITE      = 4'd3,
      MODE_BLACK      = 4'd4,
      MODE_GRAY       = 4'd5,
      MODE_RED_ORANGE = 4'd6,
      MODE_ORANGE     = 4'd7,
      MODE_YELLOW     = 4'd8,
      MODE_GREEN      = 4'd9,
      MODE_GREEN_CYAN = 4'd10,
      MODE_CYAN       = 4'd11,
      MODE_BLUE       = 4'd12,
      MODE_VIOLET     = 4'd13,
      MODE_ANY        = 4'd14
   } mode_type;

   localparam int ModeWidth   = 4;
   localparam int CsrAddrWidth = 3;

   // fixed-point reciprocal numerators, 12 fractional bits
   localparam int SatNumer = 1044480;   // 255 << 12
   localparam int HueNumer = 122880;    // 30 << 12
   localparam int SatRecipWidth = 20;
   localparam int HueRecipWidth = 17;

   localparam logic [20:0] RoundHalf = 21'd2048;
   localparam logic signed [20:0] HueBias = 21'sd133120;  // rounding plus 32 << 12

   typedef logic [255:0][SatRecipWidth-1:0] sat_table_type;
   typedef logic [255:0][HueRecipWidth-1:0] hue_table_type;

   typedef struct packed {
      logic [7:0] hl;
      logic [7:0] hh;
      logic [7:0] sl;
      logic [7:0] sh;
      logic [7:0] vl;
      logic [7:0] vh;
   } band_type;

   // converted pixel passed from the hsv pipe to the threshold stage
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hsv_item_type;

   // shift-subtract quotient, evaluated only while building the tables
   function automatic logic [31:0] quotient(input logic [31:0] num, input logic [31:0] den);
      logic [32:0] rem;
      logic [31:0] q;
      rem = '0;
      q   = '0;
      for (int i = 31; i >= 0; i--) begin
         rem = {rem[31:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sat_table_type build_sat_table();
      sat_table_type t;
      logic [31:0] q;
      t = '0;
      for (int i = 1; i < 256; i++) begin
         q    = quotient(32'(2 * SatNumer + i), 32'(2 * i));
         t[i] = q[SatRecipWidth-1:0];
      end
      return t;
   endfunction

   function automatic hue_table_type build_hue_table();
      hue_table_type t;
      logic [31:0] q;
      t = '0;
      for (int i = 1; i < 256; i++) begin
         q    = quotient(32'(2 * HueNumer + i), 32'(2 * i));
         t[i] = q[HueRecipWidth-1:0];
      end
      return t;
   endfunction

   localparam sat_table_type SatRecip = build_sat_table();
   localparam hue_table_type HueRecip = build_hue_table();

   // h, s, v limits of the single-band modes
   function automatic band_type mode_band(input logic [ModeWidth-1:0] mode);
      band_type b;
      case (mode)
         MODE_WHITE:       b = '{8'd0,   8'd180, 8'd0,   8'd30,  8'd221, 8'd255};
         MODE_BLACK:       b = '{8'd0,   8'd180, 8'd0,   8'd255, 8'd0,   8'd46};
         MODE_GRAY:        b = '{8'd0,   8'd180, 8'd0,   8'd43,  8'd46,  8'd220};
         MODE_RED_ORANGE:  b = '{8'd0,   8'd25,  8'd240, 8'd255, 8'd110, 8'd190};
         MODE_ORANGE:      b = '{8'd11,  8'd25,  8'd43,  8'd255, 8'd46,  8'd255};
         MODE_YELLOW:      b = '{8'd26,  8'd40,  8'd43,  8'd255, 8'd46,  8'd255};
         MODE_GREEN:       b = '{8'd35,  8'd77,  8'd43,  8'd255, 8'd46,  8'd255};
         MODE_GREEN_CYAN:  b = '{8'd65,  8'd99,  8'd43,  8'd255, 8'd46,  8'd255};
         MODE_CYAN:        b = '{8'd78,  8'd99,  8'd43,  8'd255, 8'd46,  8'd255};
         MODE_BLUE:        b = '{8'd100, 8'd124, 8'd43,  8'd255, 8'd46,  8'd255};
         MODE_VIOLET:      b = '{8'd125, 8'd155, 8'd43,  8'd255, 8'd46,  8'd255};
         default:          b = '{8'd0,   8'd180, 8'd43,  8'd255, 8'd46,  8'd255};
      endcase
      return b;
   endfunction

endpackage

// File: sv/hsvcrm_if.sv
// hsvcrm_req_if, hsvcrm_rsp_if: valid/ready channels for pixels and results
// no dependencies
`timescale 1ns / 1ps

interface hsvcrm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_blue;
   logic [7:0] in_green;
   logic [7:0] in_red;

   modport source(output valid, output in_blue, output in_green, output in_red,
                  input ready);
   modport sink(input valid, input in_blue, input in_green, input in_red,
                output ready);
endinterface

interface hsvcrm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       in_range;

   modport source(output valid, output out_blue, output out_green, output out_red,
                  output in_range, input ready);
   modport sink(input valid, input out_blue, input out_green, input out_red,
                input in_range, output ready);
endinterface

// File: sv/hsvcrm_hsv_pipe.sv
// hsvcrm_hsv_pipe: four-stage bgr to 8-bit hsv conversion pipeline
// depends on hsvcrm_pkg and hsvcrm_req_if
`timescale 1ns / 1ps

module hsvcrm_hsv_pipe (
   input  logic                      clock,
   input  logic                      reset,
   hsvcrm_req_if.sink                req_chan,
   output logic                      item_valid,
   input  logic                      item_ready,
   output hsvcrm_pkg::hsv_item_type  item
);

   // stage 1: max, min, spread, hue numerator
   logic                 v1_ff;
   logic [23:0]          pix1_ff, pix1_in;
   logic [7:0]           val1_ff, val1_in;
   logic [7:0]           diff1_ff, diff1_in;
   logic signed [11:0]   num1_ff, num1_in;

   // stage 2: reciprocal lookups
   logic                 v2_ff;
   logic [23:0]          pix2_ff;
   logic [7:0]           val2_ff;
   logic [7:0]           diff2_ff;
   logic signed [11:0]   num2_ff;
   logic [hsvcrm_pkg::SatRecipWidth-1:0] srec2_ff;
   logic [hsvcrm_pkg::HueRecipWidth-1:0] hrec2_ff;

   // stage 3: products
   logic                 v3_ff;
   logic [23:0]          pix3_ff;
   logic [7:0]           val3_ff;
   logic [20:0]          sprod3_ff, sprod3_in;
   logic signed [20:0]   hprod3_ff, hprod3_in;
   logic [27:0]          sprod_full;
   logic signed [29:0]   hprod_full;

   // stage 4: rounding and wrap
   logic                 v4_ff;
   hsvcrm_pkg::hsv_item_type item4_ff, item4_in;
   logic [20:0]          ssum;
   logic [8:0]           sat_raw;
   logic signed [20:0]   hsum;
   logic [7:0]           hq;

   logic en1, en2, en3, en4;
   logic [7:0] b, g, r, mx, mn;

   assign en4 = !v4_ff || item_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   assign b = req_chan.in_blue;
   assign g = req_chan.in_green;
   assign r = req_chan.in_red;

   always_comb begin
      mx = b;
      if (g > mx) mx = g;
      if (r > mx) mx = r;
      mn = b;
      if (g < mn) mn = g;
      if (r < mn) mn = r;
      diff1_in = mx - mn;
      val1_in  = mx;
      pix1_in  = {b, g, r};
      // red wins ties, then green
      if (mx == r) begin
         num1_in = $signed({4'd0, g}) - $signed({4'd0, b});
      end else if (mx == g) begin
         num1_in = $signed({4'd0, b}) - $signed({4'd0, r}) + $signed({3'd0, diff1_in, 1'b0});
      end else begin
         num1_in = $signed({4'd0, r}) - $signed({4'd0, g}) + $signed({2'd0, diff1_in, 2'b0});
      end
   end

   assign sprod_full = diff2_ff * srec2_ff;
   assign hprod_full = num2_ff * $signed({1'b0, hrec2_ff});
   assign sprod3_in  = sprod_full[20:0];
   assign hprod3_in  = hprod_full[20:0];

   always_comb begin
      ssum    = sprod3_ff + hsvcrm_pkg::RoundHalf;
      sat_raw = ssum[20:12];
      hsum    = hprod3_ff + hsvcrm_pkg::HueBias;
      hq      = hsum[19:12];
      item4_in.blue  = pix3_ff[23:16];
      item4_in.green = pix3_ff[15:8];
      item4_in.red   = pix3_ff[7:0];
      item4_in.val   = val3_ff;
      item4_in.sat   = sat_raw[8] ? 8'd255 : sat_raw[7:0];
      // wrap negative hue back into 0..179
      item4_in.hue   = (hq < 8'd32) ? 8'(hq + 8'd148) : 8'(hq - 8'd32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pix1_ff  <= pix1_in;
         val1_ff  <= val1_in;
         diff1_ff <= diff1_in;
         num1_ff  <= num1_in;
      end
      if (en2) begin
         pix2_ff  <= pix1_ff;
         val2_ff  <= val1_ff;
         diff2_ff <= diff1_ff;
         num2_ff  <= num1_ff;
         srec2_ff <= hsvcrm_pkg::SatRecip[val1_ff];
         hrec2_ff <= hsvcrm_pkg::HueRecip[diff1_ff];
      end
      if (en3) begin
         pix3_ff   <= pix2_ff;
         val3_ff   <= val2_ff;
         sprod3_ff <= sprod3_in;
         hprod3_ff <= hprod3_in;
      end
      if (en4) begin
         item4_ff <= item4_in;
      end
   end

   assign item_valid = v4_ff;
   assign item       = item4_ff;

   // hue stays on the 0..179 scale
   hue_scale_chk: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> item.hue < 8'd180)
      else $error("hue out of range");

   // a gray pixel carries hue and saturation of zero
   gray_chk: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.blue == item.green && item.green == item.red
      |-> item.hue == 8'd0 && item.sat == 8'd0)
      else $error("gray pixel with nonzero hue or saturation");

endmodule

// File: sv/hsv_color_range_mask_top.sv
// hsv_color_range_mask_top: hsv color band mask with apb-style mode register
// depends on hsvcrm_pkg, hsvcrm_if and hsvcrm_hsv_pipe
`timescale 1ns / 1ps

// One bgr pixel is taken per transfer on req_chan and one result leaves on
// rsp_chan for each, in order. The block sustains one pixel per clock while rsp_chan
// is ready; a pixel passes through four stages of the hsv conversion pipe (min/max,
// reciprocal tables, multiplies, rounding) and the band compare feeding
// the output register. Backpressure
// on rsp_chan stalls the whole chain without dropping anything. Saturation and
// hue use 12-bit fractional reciprocals of max and max-min taken from constant
// tables, so the divisions cost one lookup and one multiply each. The mode
// register sits at csr address 0 and must only be written while no pixel is
// in flight: 0 passes pixels through, 1 gives a 255/0 brown mask, 2 selects
// red (two hue bands), 3..14 select the other color bands, and 15 acts like 0.

module hsv_color_range_mask_top (
   input  logic                                  clock,
   input  logic                                  reset,
   hsvcrm_req_if.sink                            req_chan,
   hsvcrm_rsp_if.source                          rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hsvcrm_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   // mode register
   logic [hsvcrm_pkg::ModeWidth-1:0] mode_ff;
   logic                             mode_sel;
   logic                             csr_write;

   // hsv pipe output
   logic                      hsv_valid;
   logic                      hsv_ready;
   hsvcrm_pkg::hsv_item_type  hsv;

   // band compare
   hsvcrm_pkg::band_type band;
   logic       hit;
   logic       pass_all;
   logic       mask_out;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] red_ff, red_in;
   logic       range_ff, range_in;
   logic       rsp_en;

   // csr access: no wait states, one register at index 0
   assign csr_pready = 1'b1;
   assign mode_sel   = (csr_paddr[hsvcrm_pkg::CsrAddrWidth-1] == 1'b0);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = mode_sel ? {28'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hsvcrm_pkg::MODE_FULL;
      end else if (csr_write && mode_sel) begin
         mode_ff <= csr_pwdata[hsvcrm_pkg::ModeWidth-1:0];
      end
   end

   hsvcrm_hsv_pipe u_hsv_pipe (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (hsv_valid),
      .item_ready (hsv_ready),
      .item       (hsv)
   );

   // output register frees as soon as its result transfers
   assign rsp_en    = !rsp_valid_ff || rsp_chan.ready;
   assign hsv_ready = rsp_en;

   assign band = hsvcrm_pkg::mode_band(mode_ff);

   always_comb begin
      pass_all = 1'b0;
      mask_out = 1'b0;
      hit      = 1'b0;
      case (mode_ff)
         hsvcrm_pkg::MODE_BROWN: begin
            mask_out = 1'b1;
            hit = (hsv.hue <= 8'd20) && (hsv.sat inside {[8'd110:8'd210]}) &&
                  (hsv.val inside {[8'd20:8'd60]});
         end
         hsvcrm_pkg::MODE_RED: begin
            // red wraps around hue zero
            hit = (hsv.hue inside {[8'd0:8'd10], [8'd156:8'd180]}) &&
                  (hsv.sat >= 8'd43) && (hsv.val >= 8'd46);
         end
         hsvcrm_pkg::MODE_WHITE, hsvcrm_pkg::MODE_BLACK, hsvcrm_pkg::MODE_GRAY,
         hsvcrm_pkg::MODE_RED_ORANGE, hsvcrm_pkg::MODE_ORANGE,
         hsvcrm_pkg::MODE_YELLOW, hsvcrm_pkg::MODE_GREEN,
         hsvcrm_pkg::MODE_GREEN_CYAN, hsvcrm_pkg::MODE_CYAN,
         hsvcrm_pkg::MODE_BLUE, hsvcrm_pkg::MODE_VIOLET,
         hsvcrm_pkg::MODE_ANY: begin
            hit = (hsv.hue >= band.hl) && (hsv.hue <= band.hh) &&
                  (hsv.sat >= band.sl) && (hsv.sat <= band.sh) &&
                  (hsv.val >= band.vl) && (hsv.val <= band.vh);
         end
         default: begin
            // full pass and the unused code
            pass_all = 1'b1;
            hit      = 1'b1;
         end
      endcase

      range_in = hit;
      if (mask_out) begin
         blue_in  = hit ? 8'd255 : 8'd0;
         green_in = blue_in;
         red_in   = blue_in;
      end else begin
         blue_in  = hit ? hsv.blue  : 8'd0;
         green_in = hit ? hsv.green : 8'd0;
         red_in   = hit ? hsv.red   : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_valid_ff <= hsv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_en) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         range_ff <= range_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_blue  = blue_ff;
   assign rsp_chan.out_green = green_ff;
   assign rsp_chan.out_red   = red_ff;
   assign rsp_chan.in_range  = range_ff;

   // a pixel outside the bands always leaves as black
   miss_zero_chk: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.in_range
      |-> rsp_chan.out_blue == 8'd0 && rsp_chan.out_green == 8'd0 &&
          rsp_chan.out_red == 8'd0)
      else $error("unmatched pixel not zeroed");

   // brown mode gives a gray-level mask that agrees with in_range
   brown_mask_chk: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && mode_ff == hsvcrm_pkg::MODE_BROWN
      |-> rsp_chan.out_blue == rsp_chan.out_green &&
          rsp_chan.out_green == rsp_chan.out_red &&
          rsp_chan.out_red == (rsp_chan.in_range ? 8'd255 : 8'd0))
      else $error("brown mask output inconsistent");

   // pass mode forwards the pixel that left the hsv pipe
   pass_chk: assert property (@(posedge clock) disable iff (reset)
      hsv_valid && hsv_ready && pass_all
      |=> rsp_chan.valid && rsp_chan.in_range && rsp_chan.out_blue == $past(hsv.blue) &&
          rsp_chan.out_red == $past(hsv.red))
      else $error("pass mode altered the pixel");

endmodule
